// File: design/ths_pkg.sv
`timescale 1ns / 1ps
// ths_pkg: shared types and constants for the two-key helper select block
// no dependencies; used by the controller, datapath and top level

package ths_pkg;

  localparam int ADDR_W      = 48;
  localparam int STATUS_W    = 8;
  localparam int DIST_W      = 16;
  localparam int RANK_W      = 4;
  localparam int HN_W        = 5;
  localparam int MAX_RESULTS = 16;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 80;
  localparam int OUT_USER_W  = 4;

  // register index, taken from paddr bit 3
  localparam logic REG_HELPERS = 1'b0;
  localparam logic REG_SELF    = 1'b1;

  typedef struct packed {
    logic load;
    logic start;
    logic scan_rd;
    logic pick;
    logic fetch;
    logic out_load;
    logic out_empty;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic take_zero;
    logic scan_last;
    logic rank_last;
    logic out_last;
    logic out_free;
  } sts_t;

endpackage

// File: design/ths_ram.sv
`timescale 1ns / 1ps
// ths_ram: generic single write port, single read port RAM with registered read
// no dependencies

module ths_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/ths_ctrl.sv
`timescale 1ns / 1ps
// ths_ctrl: sequencer for loading, selection passes and result emission
// depends on ths_pkg for the command and status structs

module ths_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tlast,
  output logic          s_tready,
  input  ths_pkg::sts_t sts,
  output ths_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_START = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_TAIL  = 8'b0000_1000,
    S_PICK  = 8'b0001_0000,
    S_FETCH = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_EMPTY = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_LOAD);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_LOAD: begin
        cmd.load = s_tvalid;
        if (s_tvalid && s_tlast) begin
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = sts.take_zero ? S_EMPTY : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        state_next = S_PICK;
      end
      S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = sts.rank_last ? S_FETCH : S_SCAN;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.out_last) begin
            cmd.clear  = 1'b1;
            state_next = S_LOAD;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.out_empty = 1'b1;
          cmd.clear     = 1'b1;
          state_next    = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

// File: design/ths_datapath.sv
`timescale 1ns / 1ps
// ths_datapath: entry store, selection scan, rank order and output register
// depends on ths_pkg and ths_ram

module ths_datapath #(
  parameter int CAPACITY      = 16,
  parameter int DISTANCE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ths_pkg::cmd_t                      cmd,
  output ths_pkg::sts_t                      sts,
  input  logic [ths_pkg::ADDR_W-1:0]         in_addr,
  input  logic [ths_pkg::STATUS_W-1:0]       in_status,
  input  logic [ths_pkg::DIST_W-1:0]         in_dist,
  input  logic [ths_pkg::HN_W-1:0]           helpers_needed,
  input  logic [ths_pkg::ADDR_W-1:0]         self_addr,
  input  logic                               m_tready,
  output logic                               m_tvalid,
  output logic [ths_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic [ths_pkg::OUT_USER_W-1:0]     m_tuser,
  output logic                               m_tlast
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = ths_pkg::ADDR_W + ths_pkg::STATUS_W + DISTANCE_BITS;
  localparam int KW = ths_pkg::STATUS_W + DISTANCE_BITS + IW;

  logic [CW-1:0]                   cnt;
  logic                            dropped;
  logic [IW-1:0]                   scan_idx;
  logic                            pipe_v;
  logic [IW-1:0]                   pipe_idx;
  logic [KW-1:0]                   best_key;
  logic                            best_found;
  logic [ths_pkg::ADDR_W-1:0]      best_addr;
  logic [KW-1:0]                   prev_key;
  logic                            has_prev;
  logic                            chosen;
  logic [ths_pkg::HN_W-1:0]        rank;
  logic [ths_pkg::HN_W-1:0]        out_rank;
  logic [IW-1:0]                   order [ths_pkg::MAX_RESULTS];

  logic                            full;
  logic [ths_pkg::HN_W-1:0]        n_clip;
  logic [ths_pkg::HN_W-1:0]        take;
  logic [WW-1:0]                   wdata;
  logic [WW-1:0]                   rdata;
  logic [IW-1:0]                   raddr;
  logic [ths_pkg::ADDR_W-1:0]      rd_addr;
  logic [ths_pkg::STATUS_W-1:0]    rd_status;
  logic [DISTANCE_BITS-1:0]        rd_dist;
  logic [KW-1:0]                   cand;
  logic                            eligible;
  logic                            better;

  assign full  = (cnt == CW'(CAPACITY));
  assign wdata = {in_addr, in_status, DISTANCE_BITS'(in_dist)};
  assign raddr = cmd.scan_rd ? scan_idx : order[out_rank[ths_pkg::RANK_W-1:0]];

  ths_ram #(
    .WIDTH(WW),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (cmd.load && !full),
    .waddr(cnt[IW-1:0]),
    .wdata(wdata),
    .re   (cmd.scan_rd || cmd.fetch),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign {rd_addr, rd_status, rd_dist} = rdata;

  // selection count limited by stored entries and result cap
  always_comb begin
    n_clip = (32'(cnt) > 32'(ths_pkg::MAX_RESULTS)) ? ths_pkg::HN_W'(ths_pkg::MAX_RESULTS)
                                                     : ths_pkg::HN_W'(cnt);
    take   = (helpers_needed < n_clip) ? helpers_needed : n_clip;
  end

  // index in the key keeps the order stable and every key distinct
  assign cand     = {rd_status, rd_dist, pipe_idx};
  assign eligible = !has_prev || (cand > prev_key);
  assign better   = !best_found || (cand < best_key);

  assign sts.take_zero = (take == '0);
  assign sts.scan_last = (32'(scan_idx) + 32'd1 == 32'(cnt));
  assign sts.rank_last = (rank + 1'b1 == take);
  assign sts.out_last  = (out_rank + 1'b1 == take);
  assign sts.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      dropped    <= 1'b0;
      pipe_v     <= 1'b0;
      best_found <= 1'b0;
      has_prev   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      pipe_v <= cmd.scan_rd;
      if (cmd.load) begin
        if (full) begin
          dropped <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      if (cmd.clear) begin
        cnt     <= '0;
        dropped <= 1'b0;
      end
      if (cmd.start) begin
        best_found <= 1'b0;
        has_prev   <= 1'b0;
      end else if (cmd.pick) begin
        best_found <= 1'b0;
        has_prev   <= 1'b1;
      end else if (pipe_v && eligible && better) begin
        best_found <= 1'b1;
      end
      if (cmd.out_load || cmd.out_empty) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx <= scan_idx;
    if (cmd.start) begin
      scan_idx <= '0;
      rank     <= '0;
      out_rank <= '0;
      chosen   <= 1'b0;
    end
    if (cmd.scan_rd) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (pipe_v && eligible && better) begin
      best_key  <= cand;
      best_addr <= rd_addr;
    end
    if (cmd.pick) begin
      order[rank[ths_pkg::RANK_W-1:0]] <= best_key[IW-1:0];
      prev_key <= best_key;
      rank     <= rank + 1'b1;
      scan_idx <= '0;
      if (best_addr == self_addr) begin
        chosen <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_rank <= out_rank + 1'b1;
      m_tdata  <= {4'b0, out_rank[ths_pkg::RANK_W-1:0],
                   ths_pkg::DIST_W'(rd_dist), rd_status, rd_addr};
      m_tuser  <= {dropped, chosen, (rd_addr == self_addr), 1'b1};
      m_tlast  <= sts.out_last;
    end else if (cmd.out_empty) begin
      m_tdata <= '0;
      m_tuser <= {dropped, 3'b000};
      m_tlast <= 1'b1;
    end
  end

endmodule

// File: design/two_key_top_k_helper_select.sv
`timescale 1ns / 1ps
// Usage:
//   Entries arrive on the s_ stream, one beat each, while s_tready is high
//   (one beat per cycle during loading). Up to CAPACITY entries are kept in
//   arrival order; later ones in the round are dropped and flagged.
//   The beat with s_tlast closes the round. s_tready then stays low while the
//   block selects the best helpers_needed entries, capped at the stored count
//   and at MAX_RESULTS, by status, then distance, then arrival order.
//   Selection takes one pass over the n stored entries per result. Each
//   result is then read from the store and loaded into the output register;
//   with nothing selected one empty beat (tuser bit 0 low) is emitted instead.
//   Results leave on the m_ stream through an output register; m_tlast marks
//   the final result. When m_tready is low the register holds its beat and
//   emission waits. After the final result is registered the block takes
//   entries again, even while that beat still waits.
//   Configuration: helpers_needed at byte address 0, self_addr at 8, to be
//   written over the APB port while the block is idle; not enforced by the block.
//   Reset clears the entry count, the overflow flag, the configuration registers
//   and the output valid; the entry store itself needs no clearing pass.

module two_key_top_k_helper_select #(
  parameter int CAPACITY      = 16,
  parameter int DISTANCE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // node_addr[47:0], node_status[55:48], node_distance[71:56]
  input  logic [ths_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // helper_addr[47:0], helper_status[55:48], helper_distance[71:56], rank[75:72]
  output logic [ths_pkg::OUT_DATA_W-1:0]    m_tdata,
  // helper_valid[0], is_self[1], self_chosen[2], overflow[3]
  output logic [ths_pkg::OUT_USER_W-1:0]    m_tuser,
  output logic                              m_tlast,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [63:0]                       pwdata,
  output logic [63:0]                       prdata,
  output logic                              pready
);

  logic [ths_pkg::HN_W-1:0]   helpers_needed;
  logic [ths_pkg::ADDR_W-1:0] self_addr;
  ths_pkg::cmd_t              cmd;
  ths_pkg::sts_t              sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      helpers_needed <= '0;
      self_addr      <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3])
        ths_pkg::REG_HELPERS: helpers_needed <= pwdata[ths_pkg::HN_W-1:0];
        ths_pkg::REG_SELF:    self_addr      <= pwdata[ths_pkg::ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      ths_pkg::REG_HELPERS: prdata = 64'(helpers_needed);
      ths_pkg::REG_SELF:    prdata = 64'(self_addr);
      default:              prdata = '0;
    endcase
  end

  ths_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tlast (s_tlast),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  ths_datapath #(
    .CAPACITY     (CAPACITY),
    .DISTANCE_BITS(DISTANCE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_addr       (s_tdata[47:0]),
    .in_status     (s_tdata[55:48]),
    .in_dist       (s_tdata[71:56]),
    .helpers_needed(helpers_needed),
    .self_addr     (self_addr),
    .m_tready      (m_tready),
    .m_tvalid      (m_tvalid),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast)
  );

endmodule

// File: design/ths_checker.sv
`timescale 1ns / 1ps
// ths_checker: port-level assertions for the helper select top level
// depends on ths_pkg; bound to two_key_top_k_helper_select below

module ths_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           s_tlast,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ths_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [ths_pkg::OUT_USER_W-1:0] m_tuser,
  input logic                           m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == '0) && !m_tuser[1] && !m_tuser[2])
    else $error("empty result not a lone zero beat");

  a_self: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[2])
    else $error("is_self without self_chosen");

  a_close: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input still open after closing beat");

endmodule

bind two_key_top_k_helper_select ths_checker u_ths_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tlast (s_tlast),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

// File: tb/sv/two_key_top_k_helper_select_test.sv
`timescale 1ns / 1ps
// two_key_top_k_helper_select_test: stimulus table, random rounds and an in-line
// predictor of the stable status/distance ranking, checked beat by beat
// depends on ths_pkg and the two_key_top_k_helper_select top level

module two_key_top_k_helper_select_test;

  localparam int CAPACITY    = 16;
  localparam int RANDOM_ITEMS = 480;
  localparam int DRAIN       = 40;
  localparam int LIMIT       = 500000;

  typedef struct packed {
    logic [ths_pkg::ADDR_W-1:0]   addr;
    logic [ths_pkg::STATUS_W-1:0] status;
    logic [ths_pkg::DIST_W-1:0]   distance;
    logic [ths_pkg::RANK_W-1:0]   rank;
    logic                         valid;
    logic                         is_self;
    logic                         chosen;
    logic                         overflow;
    logic                         last;
  } helper_t;

  typedef enum logic [1:0] {ROW_ENTRY, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t                    kind;
    logic                         sel;
    logic [63:0]                  value;
    logic [ths_pkg::ADDR_W-1:0]   addr;
    logic [ths_pkg::STATUS_W-1:0] status;
    logic [ths_pkg::DIST_W-1:0]   distance;
    logic                         last;
    int                           reps;
    bit                           known;
    helper_t                      want;
  } stim_row_t;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  // node_addr[47:0], node_status[55:48], node_distance[71:56]
  logic [ths_pkg::IN_DATA_W-1:0]   s_tdata;
  logic                            s_tlast;
  logic                            m_tvalid;
  logic                            m_tready;
  // helper_addr[47:0], helper_status[55:48], helper_distance[71:56], rank[75:72]
  logic [ths_pkg::OUT_DATA_W-1:0]  m_tdata;
  // helper_valid[0], is_self[1], self_chosen[2], overflow[3]
  logic [ths_pkg::OUT_USER_W-1:0]  m_tuser;
  logic                            m_tlast;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [3:0]                      paddr;
  logic [63:0]                     pwdata;
  logic [63:0]                     prdata;
  logic                            pready;

  // predictor state
  logic [ths_pkg::ADDR_W-1:0]   resp_addr [CAPACITY];
  logic [ths_pkg::STATUS_W-1:0] resp_status [CAPACITY];
  logic [ths_pkg::DIST_W-1:0]   resp_dist [CAPACITY];
  int                           resp_count;
  bit                           resp_dropped;
  logic [ths_pkg::HN_W-1:0]     cfg_helpers;
  logic [ths_pkg::ADDR_W-1:0]   cfg_self;

  helper_t   pending_helpers[$];
  stim_row_t plan[$];
  int        fault_count;
  int        items_sent;
  int        cycle_count;
  int        ready_hold;
  bit        sink_calm;
  bit        src_calm;

  two_key_top_k_helper_select uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("two_key_top_k_helper_select: mismatch");
      $finish;
    end
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    fault_count++;
    $display("%0t %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // stores one response and, on the closing beat, ranks the round
  function automatic void absorb_response(logic [ths_pkg::ADDR_W-1:0] a,
                                          logic [ths_pkg::STATUS_W-1:0] st,
                                          logic [ths_pkg::DIST_W-1:0] d,
                                          logic last, bit known, helper_t want);
    int      order [CAPACITY];
    int      n;
    int      take;
    int      i;
    int      j;
    bit      chosen;
    helper_t r;
    if (resp_count < CAPACITY) begin
      resp_addr[resp_count]   = a;
      resp_status[resp_count] = st;
      resp_dist[resp_count]   = d;
      resp_count++;
    end else begin
      resp_dropped = 1'b1;
    end
    if (!last) return;
    n = resp_count;
    for (i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && (resp_status[order[j-1]] > resp_status[i] ||
             (resp_status[order[j-1]] == resp_status[i] &&
              resp_dist[order[j-1]] > resp_dist[i]))) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    take = (int'(cfg_helpers) > n) ? n : int'(cfg_helpers);
    if (take > ths_pkg::MAX_RESULTS) take = ths_pkg::MAX_RESULTS;
    chosen = 1'b0;
    for (i = 0; i < take; i++)
      if (resp_addr[order[i]] == cfg_self) chosen = 1'b1;
    if (known) begin
      pending_helpers.push_back(want);
    end else if (take == 0) begin
      r = '0;
      r.overflow = resp_dropped;
      r.last = 1'b1;
      pending_helpers.push_back(r);
    end else begin
      for (i = 0; i < take; i++) begin
        r.addr     = resp_addr[order[i]];
        r.status   = resp_status[order[i]];
        r.distance = resp_dist[order[i]];
        r.rank     = i[ths_pkg::RANK_W-1:0];
        r.valid    = 1'b1;
        r.is_self  = (resp_addr[order[i]] == cfg_self);
        r.chosen   = chosen;
        r.overflow = resp_dropped;
        r.last     = (i + 1 == take);
        pending_helpers.push_back(r);
      end
    end
    resp_count   = 0;
    resp_dropped = 1'b0;
  endfunction

  function automatic stim_row_t entry_row(logic [ths_pkg::ADDR_W-1:0] a,
                                          logic [ths_pkg::STATUS_W-1:0] st,
                                          logic [ths_pkg::DIST_W-1:0] d,
                                          logic last, int reps);
    stim_row_t row;
    row.kind     = ROW_ENTRY;
    row.sel      = ths_pkg::REG_HELPERS;
    row.value    = '0;
    row.addr     = a;
    row.status   = st;
    row.distance = d;
    row.last     = last;
    row.reps     = reps;
    row.known    = 1'b0;
    row.want     = '0;
    return row;
  endfunction

  function automatic stim_row_t known_row(logic [ths_pkg::ADDR_W-1:0] a,
                                          logic [ths_pkg::STATUS_W-1:0] st,
                                          logic [ths_pkg::DIST_W-1:0] d,
                                          helper_t want);
    stim_row_t row;
    row = entry_row(a, st, d, 1'b1, 1);
    row.known = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic stim_row_t write_row(logic sel, logic [63:0] value);
    stim_row_t row;
    row = entry_row('0, '0, '0, 1'b0, 0);
    row.kind  = ROW_WRITE;
    row.sel   = sel;
    row.value = value;
    return row;
  endfunction

  // entered and left at a falling edge
  task automatic send_entry(logic [ths_pkg::ADDR_W-1:0] a,
                            logic [ths_pkg::STATUS_W-1:0] st,
                            logic [ths_pkg::DIST_W-1:0] d,
                            logic last, bit known, helper_t want);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {d, st, a};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    absorb_response(a, st, d, last, known, want);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_helpers.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(logic sel, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == ths_pkg::REG_HELPERS) cfg_helpers = value[ths_pkg::HN_W-1:0];
    else cfg_self = value[ths_pkg::ADDR_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      m_tready <= 1'b0;
      ready_hold--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : sink_check
    helper_t seen;
    helper_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen = '{addr: m_tdata[47:0], status: m_tdata[55:48], distance: m_tdata[71:56],
               rank: m_tdata[75:72], valid: m_tuser[0], is_self: m_tuser[1],
               chosen: m_tuser[2], overflow: m_tuser[3], last: m_tlast};
      if (pending_helpers.size() == 0) begin
        report("beat with nothing pending", 64'(seen.addr), '0);
      end else begin
        want = pending_helpers.pop_front();
        if (seen.addr !== want.addr)
          report("helper_addr", 64'(seen.addr), 64'(want.addr));
        if (seen.status !== want.status)
          report("helper_status", 64'(seen.status), 64'(want.status));
        if (seen.distance !== want.distance)
          report("helper_distance", 64'(seen.distance), 64'(want.distance));
        if (seen.rank !== want.rank)
          report("rank", 64'(seen.rank), 64'(want.rank));
        if (seen.valid !== want.valid)
          report("helper_valid", 64'(seen.valid), 64'(want.valid));
        if (seen.is_self !== want.is_self)
          report("is_self", 64'(seen.is_self), 64'(want.is_self));
        if (seen.chosen !== want.chosen)
          report("self_chosen", 64'(seen.chosen), 64'(want.chosen));
        if (seen.overflow !== want.overflow)
          report("overflow", 64'(seen.overflow), 64'(want.overflow));
        if (seen.last !== want.last)
          report("last_result", 64'(seen.last), 64'(want.last));
      end
      if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
      ready_hold = sink_calm ? 0 : $urandom_range(0, 15);
    end
  end

  initial begin
    logic [ths_pkg::ADDR_W-1:0]   pool [4];
    logic [ths_pkg::ADDR_W-1:0]   a;
    logic [ths_pkg::STATUS_W-1:0] st;
    logic [ths_pkg::DIST_W-1:0]   d;
    stim_row_t                    row;
    int                           k;
    int                           r;
    int                           n;

    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    m_tready     = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    ready_hold   = 0;
    sink_calm    = 1'b0;
    src_calm     = 1'b0;
    fault_count  = 0;
    items_sent   = 0;
    cycle_count  = 0;
    resp_count   = 0;
    resp_dropped = 1'b0;
    cfg_helpers  = '0;
    cfg_self     = '0;
    pool[0] = '0;
    pool[1] = '1;
    pool[2] = ths_pkg::ADDR_W'({$urandom, $urandom});
    pool[3] = ths_pkg::ADDR_W'({$urandom, $urandom});

    // nothing requested after reset, then the smallest entry matching self
    plan.push_back(known_row('1, '1, '1,
      '{addr: '0, status: '0, distance: '0, rank: '0, valid: 1'b0, is_self: 1'b0,
        chosen: 1'b0, overflow: 1'b0, last: 1'b1}));
    plan.push_back(write_row(ths_pkg::REG_HELPERS, 64'd1));
    plan.push_back(write_row(ths_pkg::REG_SELF, 64'd0));
    plan.push_back(known_row('0, '0, '0,
      '{addr: '0, status: '0, distance: '0, rank: '0, valid: 1'b1, is_self: 1'b1,
        chosen: 1'b1, overflow: 1'b0, last: 1'b1}));
    // more requested than stored, ties on both keys
    plan.push_back(write_row(ths_pkg::REG_HELPERS, 64'd16));
    plan.push_back(write_row(ths_pkg::REG_SELF, 64'hFFFF_FFFF_FFFF));
    plan.push_back(entry_row(48'h0000_0000_0001, 8'd3, 16'd10, 1'b0, 1));
    plan.push_back(entry_row(48'hFFFF_FFFF_FFFF, 8'd1, 16'd20, 1'b0, 1));
    plan.push_back(entry_row(48'h0000_0000_0002, 8'd3, 16'd10, 1'b0, 1));
    plan.push_back(entry_row(48'hAAAA_AAAA_AAAA, 8'd1, 16'd5, 1'b0, 1));
    plan.push_back(entry_row(48'h5555_5555_5555, 8'd0, 16'hFFFF, 1'b1, 1));
    // full store, the closing beat itself is dropped
    plan.push_back(write_row(ths_pkg::REG_HELPERS, 64'd3));
    plan.push_back(entry_row(48'h0123_4567_89A0, 8'h80, 16'h8000, 1'b0, CAPACITY));
    plan.push_back(entry_row(48'h0000_0000_0000, 8'h00, 16'h0000, 1'b1, 1));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[k]) begin
      row = plan[k];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_reg(row.sel, row.value);
      end else begin
        for (r = 0; r < row.reps; r++)
          send_entry(row.addr + ths_pkg::ADDR_W'(r), row.status, row.distance,
                     row.last && (r == row.reps - 1), row.known, row.want);
      end
    end

    n = items_sent + RANDOM_ITEMS;
    while (items_sent < n) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        case ($urandom_range(0, 3))
          0:       write_reg(ths_pkg::REG_HELPERS, 64'd0);
          1:       write_reg(ths_pkg::REG_HELPERS, 64'd16);
          default: write_reg(ths_pkg::REG_HELPERS, 64'($urandom_range(1, 16)));
        endcase
        if ($urandom_range(0, 1) == 0)
          write_reg(ths_pkg::REG_SELF, 64'(pool[$urandom_range(0, 3)]));
        else
          write_reg(ths_pkg::REG_SELF, {$urandom, $urandom});
      end
      src_calm = ($urandom_range(0, 4) == 0);
      r = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 16);
      for (k = 0; k < r; k++) begin
        case ($urandom_range(0, 3))
          0:       a = cfg_self;
          1:       a = pool[$urandom_range(0, 3)];
          default: a = ths_pkg::ADDR_W'({$urandom, $urandom});
        endcase
        st = ($urandom_range(0, 1) == 0) ? ths_pkg::STATUS_W'($urandom_range(0, 3))
                                         : ths_pkg::STATUS_W'($urandom_range(0, 255));
        d  = ($urandom_range(0, 1) == 0) ? ths_pkg::DIST_W'($urandom_range(0, 7))
                                         : ths_pkg::DIST_W'($urandom_range(0, 65535));
        send_entry(a, st, d, k == r - 1, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_helpers.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    while (pending_helpers.size() != 0) begin
      report("result never seen", 64'(pending_helpers[0].addr), '0);
      void'(pending_helpers.pop_front());
    end
    if (fault_count == 0) begin
      $display("two_key_top_k_helper_select: match");
    end else begin
      $display("two_key_top_k_helper_select: mismatch");
    end
    $finish;
  end

endmodule

// File: two_key_top_k_helper_select.f
design/ths_pkg.sv
design/ths_ram.sv
design/ths_ctrl.sv
design/ths_datapath.sv
design/two_key_top_k_helper_select.sv
design/ths_checker.sv
tb/sv/two_key_top_k_helper_select_test.sv
